// ===== rtl/control_frame_decoder_with_failsafe_assert.svh =====
// ----------------------------------------------------------------------------
// Control frame decoder assertion macros
// Concurrent assertion helpers for the control frame decoder.
// ----------------------------------------------------------------------------
`ifndef CONTROL_FRAME_DECODER_WITH_FAILSAFE_ASSERT_SVH
`define CONTROL_FRAME_DECODER_WITH_FAILSAFE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfd assertion failed");
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfd assertion failed");
`else
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Control frame decoder package
// Shared constants and types of the control frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  localparam logic [7:0] FOOTER_BYTE = 8'h5A;

  localparam int unsigned COUNT_W = 3;
  localparam logic [COUNT_W-1:0] COUNT_FIRST = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_LAST = 3'd7;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_VALID = 2'd1;
  localparam logic [1:0] STATUS_CSUM_ERR = 2'd2;
  localparam logic [1:0] STATUS_FOOTER_ERR = 2'd3;

  localparam int unsigned REG_W = 16;
  localparam logic REG_SAFETY = 1'b0;
  localparam logic REG_WATCHDOG = 1'b1;
  localparam logic [REG_W-1:0] SAFETY_RESET = 16'd200;
  localparam logic [REG_W-1:0] WATCHDOG_RESET = 16'd2000;
  localparam logic [REG_W-1:0] TICK_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] joy_x;
    logic [7:0] joy_y;
    logic [7:0] throttle;
    logic [7:0] brake;
  } frame_evt_t;

  typedef struct packed {
    logic signed [9:0] joy_x;
    logic signed [9:0] joy_y;
    logic [9:0] throttle;
    logic [9:0] brake;
    logic [1:0] frame_status;
    logic safety_stop;
    logic watchdog_event;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cfd_if.sv =====
// ----------------------------------------------------------------------------
// Control frame decoder channels
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfd_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface cfd_out_if;
  logic valid;
  logic ready;
  logic signed [9:0] joy_x;
  logic signed [9:0] joy_y;
  logic [9:0] throttle;
  logic [9:0] brake;
  logic [1:0] frame_status;
  logic safety_stop;
  logic watchdog_event;

  modport source (output valid, output joy_x, output joy_y, output throttle,
                  output brake, output frame_status, output safety_stop,
                  output watchdog_event, input ready);
  modport sink (input valid, input joy_x, input joy_y, input throttle,
                input brake, input frame_status, input safety_stop,
                input watchdog_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/control_frame_decoder_with_failsafe.sv =====
// ----------------------------------------------------------------------------
// Control frame decoder with failsafe
// Deframes serial control frames and forces the controls to zero on timeout.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken, set by the single result register.
// The input is ready whenever the result register is empty or being taken.
// Reset clears the framer, the tick count and the controls, and loads the
// safety and watchdog timeouts with 200 and 2000 ticks.
`default_nettype none

`include "control_frame_decoder_with_failsafe_assert.svh"

module control_frame_decoder_with_failsafe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [cfd_pkg::REG_W-1:0]  cfg_wr_data,
  cfd_in_if.sink                          item,
  cfd_out_if.source                       result
);
  import cfd_pkg::*;

  logic             accept;
  logic [REG_W-1:0] safety_timeout_ticks;
  logic [REG_W-1:0] watchdog_timeout_ticks;
  frame_evt_t       evt;
  result_t          res_next;
  result_t          res;
  logic             res_valid;

  assign item.ready = !res_valid || result.ready;
  assign accept = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_timeout_ticks <= SAFETY_RESET;
      watchdog_timeout_ticks <= WATCHDOG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAFETY: safety_timeout_ticks <= cfg_wr_data;
        REG_WATCHDOG: watchdog_timeout_ticks <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  cfd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (accept && (item.cmd == CMD_BYTE)),
    .data_byte (item.data_byte),
    .evt       (evt)
  );

  cfd_failsafe u_failsafe (
    .clk                    (clk),
    .rst                    (rst),
    .tick_en                (accept && (item.cmd == CMD_TICK)),
    .evt                    (evt),
    .safety_timeout_ticks   (safety_timeout_ticks),
    .watchdog_timeout_ticks (watchdog_timeout_ticks),
    .res                    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.joy_x = res.joy_x;
  assign result.joy_y = res.joy_y;
  assign result.throttle = res.throttle;
  assign result.brake = res.brake;
  assign result.frame_status = res.frame_status;
  assign result.safety_stop = res.safety_stop;
  assign result.watchdog_event = res.watchdog_event;

  `CFD_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !res_valid, item.ready)
  `CFD_ASSERT_IMPLY(a_stop_zeroes_controls, clk, rst, res_valid && res.safety_stop,
    (res.joy_x == 10'sd0) && (res.joy_y == 10'sd0) && (res.throttle == 10'd0) &&
    (res.brake == 10'd0))
  `CFD_ASSERT_IMPLY(a_frame_not_tick, clk, rst,
    res_valid && (res.frame_status != STATUS_NONE),
    !res.safety_stop && !res.watchdog_event)
  `CFD_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, res_valid)

endmodule

`default_nettype wire

// ===== rtl/cfd_framer.sv =====
// ----------------------------------------------------------------------------
// Control frame decoder framer
// Collects bytes into frames and checks footer and XOR checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_en,
  input  wire logic [7:0]        data_byte,
  output cfd_pkg::frame_evt_t    evt
);
  import cfd_pkg::*;

  logic                in_frame;
  logic [COUNT_W-1:0]  byte_count;
  logic [7:0]          frame_store [1:6];
  logic [7:0]          checksum;

  assign checksum = frame_store[1] ^ frame_store[2] ^ frame_store[3] ^
                    frame_store[4] ^ frame_store[5];

  always_comb begin
    evt.status = STATUS_NONE;
    evt.joy_x = frame_store[1];
    evt.joy_y = frame_store[2];
    evt.throttle = frame_store[3];
    evt.brake = frame_store[4];
    if (byte_en && in_frame && (byte_count == COUNT_LAST)) begin
      if (data_byte != FOOTER_BYTE) begin
        evt.status = STATUS_FOOTER_ERR;
      end else if (checksum != frame_store[6]) begin
        evt.status = STATUS_CSUM_ERR;
      end else begin
        evt.status = STATUS_VALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      byte_count <= '0;
    end else if (byte_en) begin
      if (!in_frame) begin
        if (data_byte == HEADER_BYTE) begin
          in_frame <= 1'b1;
          byte_count <= COUNT_FIRST;
        end
      end else if (byte_count == COUNT_LAST) begin
        in_frame <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + COUNT_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && in_frame) begin
      for (int i = 1; i <= 6; i++) begin
        if (byte_count == COUNT_W'(i)) begin
          frame_store[i] <= data_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfd_failsafe.sv =====
// ----------------------------------------------------------------------------
// Control frame decoder failsafe
// Holds the controls and the tick count, applies safety and watchdog timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_failsafe (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         tick_en,
  input  wire cfd_pkg::frame_evt_t          evt,
  input  wire logic [cfd_pkg::REG_W-1:0]    safety_timeout_ticks,
  input  wire logic [cfd_pkg::REG_W-1:0]    watchdog_timeout_ticks,
  output cfd_pkg::result_t                  res
);
  import cfd_pkg::*;

  logic [REG_W-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [7:0] joy_x, joy_x_next, joy_y, joy_y_next;
  logic [7:0] throttle, throttle_next, brake, brake_next;
  logic safety, wdog;

  assign elapsed_inc = (elapsed == TICK_MAX) ? elapsed : elapsed + REG_W'(1);

  always_comb begin
    elapsed_next = elapsed;
    joy_x_next = joy_x;
    joy_y_next = joy_y;
    throttle_next = throttle;
    brake_next = brake;
    safety = 1'b0;
    wdog = 1'b0;
    if (tick_en) begin
      safety = elapsed_inc > safety_timeout_ticks;
      wdog = elapsed_inc > watchdog_timeout_ticks;
      elapsed_next = wdog ? '0 : elapsed_inc;
      if (safety) begin
        joy_x_next = '0;
        joy_y_next = '0;
        throttle_next = '0;
        brake_next = '0;
      end
    end else if (evt.status == STATUS_VALID) begin
      elapsed_next = '0;
      joy_x_next = evt.joy_x;
      joy_y_next = evt.joy_y;
      throttle_next = evt.throttle;
      brake_next = evt.brake;
    end
  end

  always_comb begin
    res.joy_x = $signed({joy_x_next, 2'b00});
    res.joy_y = $signed({joy_y_next, 2'b00});
    res.throttle = {throttle_next, 2'b00};
    res.brake = {brake_next, 2'b00};
    res.frame_status = evt.status;
    res.safety_stop = safety;
    res.watchdog_event = wdog;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      joy_x <= '0;
      joy_y <= '0;
      throttle <= '0;
      brake <= '0;
    end else begin
      elapsed <= elapsed_next;
      joy_x <= joy_x_next;
      joy_y <= joy_y_next;
      throttle <= throttle_next;
      brake <= brake_next;
    end
  end

endmodule

`default_nettype wire
